@@ hdl/gdad_pkg.sv @@
// Shared types, constants and calendar helpers for the date-plus-days block.
`default_nettype none
package gdad_pkg;

    localparam int unsigned DAY_W  = 18;   // signed running day count
    localparam int unsigned YEAR_W = 14;
    localparam int unsigned OFF_W  = 17;

    localparam logic [YEAR_W-1:0] YEAR_MAX    = 14'd9999;
    localparam logic [YEAR_W-1:0] YEAR_DEF    = 14'd2000;
    localparam logic [YEAR_W-1:0] YEAR_CYCLE  = 14'd400;
    localparam logic [8:0]        REM_LAST    = 9'd399;
    localparam logic [OFF_W-1:0]  OFF_MOST_NEG = 17'h10000;   // -65536
    localparam logic [OFF_W-1:0]  OFF_SAT_NEG  = 17'h10001;   // -65535

    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_DEC = 4'd12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_CHECK,
        ST_WALK,
        ST_DONE
    } t_state;

    // Gregorian leap rule from year[1:0] and year mod 400
    function automatic logic is_leap(input logic [1:0] y_lo, input logic [8:0] rem);
        is_leap = (y_lo == 2'd0) && (rem != 9'd100) && (rem != 9'd200) && (rem != 9'd300);
    endfunction

    // Days in a month; codes outside 1..12 read as 31
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        case (m)
            4'd2:    n = leap ? 5'd29 : 5'd28;
            4'd4:    n = 5'd30;
            4'd6:    n = 5'd30;
            4'd9:    n = 5'd30;
            4'd11:   n = 5'd30;
            default: n = 5'd31;
        endcase
        month_days = n;
    endfunction

endpackage
`default_nettype wire

@@ hdl/gregorian_date_add_days.sv @@
// Gregorian date plus signed day offset, month-by-month walking sequencer.
// Sequence: capture, reduce the year mod 400 by repeated subtraction, check the start,
//   walk one month at a time, then hold the result until it is taken.
// Throughput: one transaction at a time; o_ready is high only when idle.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle.
`default_nettype none
module gregorian_date_add_days (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [3:0]                   i_in_month,
    input  wire logic [4:0]                   i_in_day,
    input  wire logic [gdad_pkg::YEAR_W-1:0]  i_in_year,
    input  wire logic signed [gdad_pkg::OFF_W-1:0] i_offset_days,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [3:0]                        o_out_month,
    output logic [4:0]                        o_out_day,
    output logic [gdad_pkg::YEAR_W-1:0]       o_out_year,
    output logic                              o_input_invalid,
    output logic                              o_year_out_of_range
);
    import gdad_pkg::*;

    t_state                    r_state, n_state;
    logic [3:0]                r_m, n_m;
    logic signed [DAY_W-1:0]   r_d, n_d;
    logic [YEAR_W-1:0]         r_year, n_year;
    logic [YEAR_W-1:0]         r_rem, n_rem;     // year mod 400 once reduced
    logic [OFF_W-1:0]          r_off, n_off;
    logic                      r_bad, n_bad;
    logic                      r_range, n_range;

    logic                      leap_cur;
    logic [4:0]                days_cur;
    logic [4:0]                days_prev;
    logic signed [DAY_W-1:0]   days_ext;         // month length as a signed day count
    logic                      start_ok;
    logic signed [DAY_W-1:0]   off_ext;

    // Calendar lookups on the current walk position
    always_comb begin
        leap_cur  = is_leap(r_year[1:0], r_rem[8:0]);
        days_cur  = month_days(r_m, leap_cur);
        days_prev = month_days(r_m - 4'd1, leap_cur);
        days_ext  = DAY_W'(days_cur);
        off_ext   = DAY_W'(signed'(r_off));
        start_ok  = (r_year <= YEAR_MAX) && (r_m >= MON_JAN) && (r_m <= MON_DEC)
                    && (r_d >= DAY_W'(1)) && (r_d <= days_ext);
    end

    // State register and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bad   <= 1'b0;
            r_range <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bad   <= n_bad;
            r_range <= n_range;
        end
        r_m    <= n_m;
        r_d    <= n_d;
        r_year <= n_year;
        r_rem  <= n_rem;
        r_off  <= n_off;
    end

    // Sequencer: reduce year, validate start (an invalid start walks from 1 Jan 2000), walk months, hold result
    always_comb begin
        n_state = r_state;
        n_m     = r_m;
        n_d     = r_d;
        n_year  = r_year;
        n_rem   = r_rem;
        n_off   = r_off;
        n_bad   = r_bad;
        n_range = r_range;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_m     = i_in_month;
                    n_d     = DAY_W'(i_in_day);
                    n_year  = i_in_year;
                    n_rem   = i_in_year;
                    n_off   = (i_offset_days == OFF_MOST_NEG) ? OFF_SAT_NEG : i_offset_days;
                    n_bad   = 1'b0;
                    n_range = 1'b0;
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                // one subtract of 400 per cycle
                if (r_rem >= YEAR_CYCLE) begin
                    n_rem = r_rem - YEAR_CYCLE;
                end else begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (start_ok) begin
                    n_d = r_d + off_ext;
                end else begin
                    n_bad  = 1'b1;
                    n_m    = MON_JAN;
                    n_year = YEAR_DEF;
                    n_rem  = '0;
                    n_d    = DAY_W'(1) + off_ext;
                end
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (r_d > days_ext) begin
                    // forward one month
                    n_d = r_d - days_ext;
                    if (r_m == MON_DEC) begin
                        if (r_year == YEAR_MAX) begin
                            n_range = 1'b1;
                            n_m     = MON_DEC;
                            n_d     = DAY_W'(31);
                            n_state = ST_DONE;
                        end else begin
                            n_m    = MON_JAN;
                            n_year = r_year + 14'd1;
                            n_rem  = (r_rem[8:0] == REM_LAST) ? '0 : r_rem + 14'd1;
                        end
                    end else begin
                        n_m = r_m + 4'd1;
                    end
                end else if (r_d < DAY_W'(1)) begin
                    // back one month
                    if (r_m == MON_JAN) begin
                        if (r_year == '0) begin
                            n_range = 1'b1;
                            n_m     = MON_JAN;
                            n_d     = DAY_W'(1);
                            n_state = ST_DONE;
                        end else begin
                            n_m    = MON_DEC;
                            n_year = r_year - 14'd1;
                            n_rem  = (r_rem == '0) ? YEAR_W'(REM_LAST) : r_rem - 14'd1;
                            n_d    = r_d + DAY_W'(31);
                        end
                    end else begin
                        n_m = r_m - 4'd1;
                        n_d = r_d + DAY_W'(days_prev);
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    assign o_ready             = (r_state == ST_IDLE);
    assign o_valid             = (r_state == ST_DONE);
    assign o_out_month         = r_m;
    assign o_out_day           = r_d[4:0];
    assign o_out_year          = r_year;
    assign o_input_invalid     = r_bad;
    assign o_year_out_of_range = r_range;

endmodule
`default_nettype wire
